// ===== hdl/scl_pkg.sv =====
// scl_pkg: shared constants and types of the single coverage length core.
// No dependencies.
`timescale 1ns / 1ps

package scl_pkg;

  localparam int unsigned FIELD_W = 31;

  typedef struct packed {
    logic clear;
    logic take;
    logic first;
  } sweep_ctrl_t;

endpackage

// ===== hdl/single_coverage_length_core.sv =====
// single_coverage_length_core: top level; load, sort chain, sweep and result register.
// Depends on scl_pkg, scl_cell, scl_sweep.
//
// Usage: segments come in on the input channel (seg_start_i, seg_end_i,
// last_segment_i, in_valid_i / in_ready_o); while loading, each item pushes
// its start key and then its end key into a chain of 2*MAX_SEGMENTS sort
// cells, one key per cycle, so the chain sorts as it loads, and the next
// item is taken only once both keys of the last are in. The item flagged
// last closes the set: the chain settles, then shifts its keys out one per
// cycle into the sweep unit, and the result is written to the output
// register; in_ready_o stays low until then. Segments beyond MAX_SEGMENTS
// are dropped and set overflow_o. The output channel (exact_once_length_o,
// overflow_o, out_valid_o / out_ready_i) holds one result; once it is
// written, the next set may load while the result waits. If the previous
// result is still held when a new one is ready, the core waits until it is
// taken. Reset empties the chain, clears the segment count, the overflow
// flag and the output valid flag.
`timescale 1ns / 1ps

module single_coverage_length_core
  import scl_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned COORD_BITS   = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FIELD_W-1:0] seg_start_i,
  input  logic [FIELD_W-1:0] seg_end_i,
  input  logic               last_segment_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FIELD_W-1:0] exact_once_length_o,
  output logic               overflow_o
);

  localparam int unsigned CW      = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int unsigned KEY_W   = CW + 1;
  localparam int unsigned NCELLS  = 2 * MAX_SEGMENTS;
  localparam int unsigned CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned TMR_W   = $clog2(NCELLS + 3);
  localparam int unsigned DEPTH_W = $clog2(NCELLS) + 2;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   seg_cnt_q, seg_cnt_d;
  logic               ovf_q, ovf_d;
  logic               pend_q, pend_d;
  logic               last_hold_q, last_hold_d;
  logic               end_valid_q, end_valid_d;
  logic [KEY_W-1:0]   end_key_q, end_key_d;
  logic               feed_valid_q, feed_valid_d;
  logic [KEY_W-1:0]   feed_key_q, feed_key_d;
  logic [TMR_W-1:0]   tmr_q, tmr_d;
  logic               out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] out_len_q, out_len_d;
  logic               out_ovf_q, out_ovf_d;

  logic               in_acc;
  logic               room;
  logic               drain;
  logic [TMR_W-1:0]   nkeys;
  sweep_ctrl_t        sw_ctrl;
  logic [FIELD_W-1:0] sw_sum;

  logic               cell_valid [NCELLS];
  logic [KEY_W-1:0]   cell_key   [NCELLS];
  logic               pass_valid [NCELLS];
  logic [KEY_W-1:0]   pass_key   [NCELLS];

  assign in_ready_o = (state_q == ST_LOAD) && !pend_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign room       = seg_cnt_q < CNT_W'(MAX_SEGMENTS);
  assign nkeys      = TMR_W'({seg_cnt_q, 1'b0});
  assign drain      = (state_q == ST_DRAIN);

  always_comb begin
    state_d      = state_q;
    seg_cnt_d    = seg_cnt_q;
    ovf_d        = ovf_q;
    pend_d       = pend_q;
    last_hold_d  = last_hold_q;
    end_valid_d  = end_valid_q;
    end_key_d    = end_key_q;
    feed_valid_d = 1'b0;
    feed_key_d   = feed_key_q;
    tmr_d        = tmr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_len_d    = out_len_q;
    out_ovf_d    = out_ovf_q;
    sw_ctrl      = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (pend_q) begin
          feed_valid_d = end_valid_q;
          feed_key_d   = end_key_q;
          pend_d       = 1'b0;
          if (last_hold_q) begin
            state_d = ST_FLUSH;
            tmr_d   = '0;
          end
        end else if (in_acc) begin
          feed_valid_d = room;
          feed_key_d   = {seg_start_i[CW-1:0], 1'b0};
          end_valid_d  = room;
          end_key_d    = {seg_end_i[CW-1:0], 1'b1};
          last_hold_d  = last_segment_i;
          pend_d       = 1'b1;
          if (room) begin
            seg_cnt_d = seg_cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        sw_ctrl.clear = (tmr_q == '0);
        tmr_d         = tmr_q + TMR_W'(1);
        if (tmr_q == nkeys + TMR_W'(1)) begin
          state_d = ST_DRAIN;
          tmr_d   = '0;
        end
      end
      ST_DRAIN: begin
        sw_ctrl.take  = (tmr_q < nkeys);
        sw_ctrl.first = (tmr_q == '0);
        tmr_d         = tmr_q + TMR_W'(1);
        if (tmr_q == nkeys) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_len_d   = sw_sum;
          out_ovf_d   = ovf_q;
          seg_cnt_d   = '0;
          ovf_d       = 1'b0;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      seg_cnt_q    <= '0;
      ovf_q        <= 1'b0;
      pend_q       <= 1'b0;
      last_hold_q  <= 1'b0;
      end_valid_q  <= 1'b0;
      feed_valid_q <= 1'b0;
      tmr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      seg_cnt_q    <= seg_cnt_d;
      ovf_q        <= ovf_d;
      pend_q       <= pend_d;
      last_hold_q  <= last_hold_d;
      end_valid_q  <= end_valid_d;
      feed_valid_q <= feed_valid_d;
      tmr_q        <= tmr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_key_q  <= end_key_d;
    feed_key_q <= feed_key_d;
    out_len_q  <= out_len_d;
    out_ovf_q  <= out_ovf_d;
  end

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    logic             in_v;
    logic [KEY_W-1:0] in_k;
    logic             nb_v;
    logic [KEY_W-1:0] nb_k;

    if (i == 0) begin : g_head
      assign in_v = feed_valid_q;
      assign in_k = feed_key_q;
    end else begin : g_body
      assign in_v = pass_valid[i-1];
      assign in_k = pass_key[i-1];
    end

    if (i == NCELLS - 1) begin : g_tail
      assign nb_v = 1'b0;
      assign nb_k = '0;
    end else begin : g_link
      assign nb_v = cell_valid[i+1];
      assign nb_k = cell_key[i+1];
    end

    scl_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .drain_i     (drain),
      .in_valid_i  (in_v),
      .in_key_i    (in_k),
      .nbr_valid_i (nb_v),
      .nbr_key_i   (nb_k),
      .valid_o     (cell_valid[i]),
      .key_o       (cell_key[i]),
      .pass_valid_o(pass_valid[i]),
      .pass_key_o  (pass_key[i])
    );
  end

  scl_sweep #(
    .CW     (CW),
    .DEPTH_W(DEPTH_W)
  ) u_sweep (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(sw_ctrl),
    .key_i (cell_key[0]),
    .sum_o (sw_sum)
  );

  assign out_valid_o         = out_valid_q;
  assign exact_once_length_o = out_len_q;
  assign overflow_o          = out_ovf_q;

  a_ready_only_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_LOAD))
    else $error("input ready outside loading");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_cnt_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (seg_cnt_q == CNT_W'(MAX_SEGMENTS)))
    else $error("overflow flagged with room left");

  a_no_feed_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> !feed_valid_q)
    else $error("key pushed while draining");

  a_chain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pass_valid[NCELLS-1])
    else $error("key fell off the end of the chain");

  a_done_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (state_q == ST_LOAD && out_valid_q))
    else $error("result not registered");

endmodule

// ===== hdl/scl_cell.sv =====
// scl_cell: one cell of the insertion sort chain; holds one endpoint key.
// No dependencies.
`timescale 1ns / 1ps

module scl_cell #(
  parameter int unsigned KEY_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             drain_i,
  input  logic             in_valid_i,
  input  logic [KEY_W-1:0] in_key_i,
  input  logic             nbr_valid_i,
  input  logic [KEY_W-1:0] nbr_key_i,
  output logic             valid_o,
  output logic [KEY_W-1:0] key_o,
  output logic             pass_valid_o,
  output logic [KEY_W-1:0] pass_key_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             pass_valid_q, pass_valid_d;
  logic [KEY_W-1:0] pass_key_q, pass_key_d;

  always_comb begin
    valid_d      = valid_q;
    key_d        = key_q;
    pass_valid_d = 1'b0;
    pass_key_d   = in_key_i;
    if (drain_i) begin
      valid_d = nbr_valid_i;
      key_d   = nbr_key_i;
    end else if (in_valid_i) begin
      if (!valid_q) begin
        valid_d = 1'b1;
        key_d   = in_key_i;
      end else if (in_key_i < key_q) begin
        key_d        = in_key_i;
        pass_valid_d = 1'b1;
        pass_key_d   = key_q;
      end else begin
        pass_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      pass_valid_q <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      pass_valid_q <= pass_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    pass_key_q <= pass_key_d;
  end

  assign valid_o      = valid_q;
  assign key_o        = key_q;
  assign pass_valid_o = pass_valid_q;
  assign pass_key_o   = pass_key_q;

endmodule

// ===== hdl/scl_sweep.sv =====
// scl_sweep: depth-count sweep over sorted endpoint keys, sums exact-once gaps.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_sweep
  import scl_pkg::*;
#(
  parameter int unsigned CW      = 31,
  parameter int unsigned DEPTH_W = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sweep_ctrl_t        ctrl_i,
  input  logic [CW:0]        key_i,
  output logic [FIELD_W-1:0] sum_o
);

  logic [CW-1:0]              open_q, open_d;
  logic signed [DEPTH_W-1:0]  depth_q, depth_d;
  logic [FIELD_W-1:0]         sum_q, sum_d;
  logic [CW-1:0]              coord;
  logic signed [DEPTH_W-1:0]  step;
  logic signed [DEPTH_W-1:0]  depth_nx;
  logic [CW-1:0]              diff;

  assign coord    = key_i[CW:1];
  assign step     = key_i[0] ? '1 : DEPTH_W'(1);
  assign depth_nx = depth_q + step;
  assign diff     = coord - open_q;

  always_comb begin
    open_d  = open_q;
    depth_d = depth_q;
    sum_d   = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.take) begin
      if (ctrl_i.first) begin
        open_d  = coord;
        depth_d = DEPTH_W'(1);
        sum_d   = '0;
      end else if (depth_q == DEPTH_W'(1)) begin
        depth_d = depth_nx;
        sum_d   = sum_q + FIELD_W'(diff);
      end else begin
        depth_d = depth_nx;
        if (depth_nx == DEPTH_W'(1)) begin
          open_d = coord;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      depth_q <= DEPTH_W'(1);
    end else begin
      sum_q   <= sum_d;
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    open_q <= open_d;
  end

  assign sum_o = sum_q;

endmodule

// ===== tb/scl_coverage_checker.sv =====
// scl_coverage_checker: watches both channels of the single coverage length core, predicts
// the exact-once length and overflow flag of each set and compares them in order.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_coverage_checker
  import scl_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned COORD_BITS   = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [FIELD_W-1:0] seg_start_i,
  input  logic [FIELD_W-1:0] seg_end_i,
  input  logic               last_segment_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [FIELD_W-1:0] exact_once_length_i,
  input  logic               overflow_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);

  localparam logic [FIELD_W-1:0] COORD_MASK = FIELD_W'((64'd1 << COORD_BITS) - 64'd1);

  typedef struct packed {
    logic [FIELD_W-1:0] length;
    logic               overflow;
  } coverage_result_t;

  // key = {coordinate, is_end}
  logic [31:0]      set_keys[$];
  coverage_result_t result_q[$];
  coverage_result_t want;
  int unsigned      seg_count;
  logic             dropped_seen;
  int unsigned      mismatch_count;

  // Stable sort of the current set, then a depth sweep summing gaps at depth one.
  function automatic logic [FIELD_W-1:0] exact_once_length();
    int unsigned     n;
    int unsigned     j;
    logic [31:0]     k;
    int              depth;
    longint unsigned total;
    longint unsigned open_at;
    longint unsigned v;
    logic            is_end;
    n = set_keys.size();
    for (int unsigned i = 1; i < n; i++) begin
      k = set_keys[i];
      j = i;
      while (j > 0 && set_keys[j-1] > k) begin
        set_keys[j] = set_keys[j-1];
        j--;
      end
      set_keys[j] = k;
    end
    if (n == 0) begin
      return '0;
    end
    depth   = 1;
    total   = 0;
    open_at = set_keys[0][31:1];
    for (int unsigned i = 1; i < n; i++) begin
      v      = set_keys[i][31:1];
      is_end = set_keys[i][0];
      if (depth == 1) begin
        depth += is_end ? -1 : 1;
        total += v - open_at;
      end else begin
        depth += is_end ? -1 : 1;
        if (depth == 1) begin
          open_at = v;
        end
      end
    end
    return total[FIELD_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_keys.delete();
      result_q.delete();
      seg_count      = 0;
      dropped_seen   = 1'b0;
      mismatch_count = 0;
      mismatches_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected result length %0d overflow %0b", $realtime,
                     exact_once_length_i, overflow_i);
          end
          mismatch_count++;
        end else begin
          want = result_q.pop_front();
          if (want.length !== exact_once_length_i || want.overflow !== overflow_i) begin
            if (mismatch_count < 10) begin
              $display("%0t: length exp %0d got %0d, overflow exp %0b got %0b", $realtime,
                       want.length, exact_once_length_i, want.overflow, overflow_i);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (seg_count < MAX_SEGMENTS) begin
          set_keys.push_back({seg_start_i & COORD_MASK, 1'b0});
          set_keys.push_back({seg_end_i & COORD_MASK, 1'b1});
          seg_count++;
        end else begin
          dropped_seen = 1'b1;
        end
        if (last_segment_i) begin
          want.length   = exact_once_length();
          want.overflow = dropped_seen;
          result_q.push_back(want);
          set_keys.delete();
          seg_count    = 0;
          dropped_seen = 1'b0;
        end
      end
      mismatches_o <= mismatch_count;
      pending_o    <= result_q.size();
    end
  end

endmodule

// ===== tb/single_coverage_length_core_tb.sv =====
// single_coverage_length_core_tb: drives directed and random segment sets into the core
// under several idle and stall mixes, and reports the verdict from scl_coverage_checker.
// Depends on scl_pkg, single_coverage_length_core, scl_coverage_checker.
`timescale 1ns / 1ps

module single_coverage_length_core_tb;
  import scl_pkg::*;

  localparam int unsigned MAX_SEGMENTS  = 256;
  localparam int unsigned COORD_BITS    = 31;
  localparam int unsigned DRAIN_CYCLES  = 4 * MAX_SEGMENTS + 64;
  localparam int unsigned PHASE_ITEMS   = 400;
  localparam logic [FIELD_W-1:0] TOP    = 31'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] ALT_A  = 31'h2AAA_AAAA;
  localparam logic [FIELD_W-1:0] ALT_B  = 31'h5555_5555;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [FIELD_W-1:0] seg_start_i;
  logic [FIELD_W-1:0] seg_end_i;
  logic               last_segment_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [FIELD_W-1:0] exact_once_length_o;
  logic               overflow_o;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned pending;

  single_coverage_length_core #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .COORD_BITS  (COORD_BITS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .seg_start_i        (seg_start_i),
    .seg_end_i          (seg_end_i),
    .last_segment_i     (last_segment_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .exact_once_length_o(exact_once_length_o),
    .overflow_o         (overflow_o)
  );

  scl_coverage_checker #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .COORD_BITS  (COORD_BITS)
  ) u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .seg_start_i        (seg_start_i),
    .seg_end_i          (seg_end_i),
    .last_segment_i     (last_segment_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .exact_once_length_i(exact_once_length_o),
    .overflow_i         (overflow_o),
    .mismatches_o       (mismatches),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_segment(input logic [FIELD_W-1:0] s, input logic [FIELD_W-1:0] e,
                              input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    seg_start_i    <= s;
    seg_end_i      <= e;
    last_segment_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Coordinates from a narrow, medium or full range; some segments reversed.
  task automatic send_random_set(input int unsigned n_seg);
    int unsigned lim;
    int unsigned s;
    int unsigned e;
    int unsigned saved_idle;
    case ($urandom_range(0, 2))
      0:       lim = 255;
      1:       lim = 65535;
      default: lim = 32'h7FFF_FFFF;
    endcase
    saved_idle = send_idle_pct;
    if ($urandom_range(0, 4) == 0) begin
      send_idle_pct = 0;
    end
    for (int unsigned i = 0; i < n_seg; i++) begin
      s = $urandom_range(0, lim);
      if ($urandom_range(0, 9) == 0) begin
        e = $urandom_range(0, lim);
      end else begin
        e = s + $urandom_range(0, (lim - s) >> $urandom_range(0, 4));
      end
      send_segment(FIELD_W'(s), FIELD_W'(e), i == n_seg - 1);
    end
    send_idle_pct = saved_idle;
  endtask

  initial begin
    int unsigned sent;
    int unsigned n_seg;
    int unsigned big;
    logic        placed;
    in_valid_i     = 1'b0;
    seg_start_i    = '0;
    seg_end_i      = '0;
    last_segment_i = 1'b0;
    out_ready_i    = 1'b0;
    rst_ni         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // point, full span, top point
    send_segment('0, '0, 1'b1);
    send_segment('0, TOP, 1'b1);
    send_segment(TOP, TOP, 1'b1);
    // disjoint, nested, touching
    send_segment(31'd0, 31'd10, 1'b0);
    send_segment(31'd20, 31'd35, 1'b1);
    send_segment(31'd0, 31'd100, 1'b0);
    send_segment(31'd10, 31'd20, 1'b1);
    send_segment(31'd0, 31'd10, 1'b0);
    send_segment(31'd10, 31'd20, 1'b1);
    // reversed segments
    send_segment(31'd50, 31'd10, 1'b1);
    send_segment(31'd30, 31'd5, 1'b0);
    send_segment(31'd0, 31'd40, 1'b1);
    // identical segments cancel
    send_segment(31'd5, 31'd15, 1'b0);
    send_segment(31'd5, 31'd15, 1'b1);
    // alternating bit patterns, both orders
    send_segment(ALT_A, ALT_B, 1'b0);
    send_segment(ALT_B, ALT_A, 1'b0);
    send_segment(TOP, '0, 1'b1);

    // phases: no idling, sender idle, receiver stall, both; one large set in each phase but the first
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  big = 0;   end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  big = 256; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; big = 257; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; big = 260; end
      endcase
      sent   = 0;
      placed = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if (!placed && big != 0 && sent >= 120) begin
          n_seg  = big;
          placed = 1'b1;
        end else begin
          n_seg = $urandom_range(1, 12);
        end
        send_random_set(n_seg);
        sent += n_seg;
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== single_coverage_length_core.f =====
hdl/scl_pkg.sv
hdl/scl_cell.sv
hdl/scl_sweep.sv
hdl/single_coverage_length_core.sv
tb/scl_coverage_checker.sv
tb/single_coverage_length_core_tb.sv
